@@ rtl/assert_macros.svh @@
// Assertion macros shared by the placer RTL.
// Used by the top level; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition that must hold at every sampled edge out of reset.
`define AGP_ASSERT(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");
// Implication checked at the same edge.
`define AGP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define AGP_ASSERT(lbl, clk, rstn, cond)
`define AGP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/agp_pkg.sv @@
// Package of the affinity group placer: sizes, request codes, field widths.
// Used by every RTL module of the block; depends on nothing.
package agp_pkg;

  localparam int MAX_THREADS_DEF = 64;
  localparam int MAX_GROUPS_DEF  = 16;
  localparam int MAX_SLOTS_DEF   = 8;

  localparam int TAG_W    = 32;
  localparam int SLOT_W   = 3;
  localparam int MEMB_W   = 7;
  localparam int LIVE_W   = 5;
  localparam int TID_W    = 6;
  localparam int REQ_W    = 2;
  localparam int SEED_W   = 7;
  localparam int SCNT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam int IN_W  = 48;
  localparam int OUT_W = 112;

  localparam logic [MEMB_W-1:0] MEMBER_MAX = 7'd127;
  localparam logic [SEED_W-1:0] SEED_MOD   = 7'd127;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_SET  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DUP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TERM = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HINT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd3;

endpackage

@@ rtl/agp_thread_mem.sv @@
// Per-thread group table: one write port, one registered read port.
// Entries not yet written read as zero through a valid bit per entry.
module agp_thread_mem #(
  parameter int DEPTH = agp_pkg::MAX_THREADS_DEF,
  parameter int AW    = 6,
  parameter int DW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  import agp_pkg::*;

  logic [DW-1:0]    mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    rd_r;
  logic             rd_vld_r;

  // Storage array, no reset.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem_r[raddr];
    end
  end

  // Valid bits make the table read as cleared after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

@@ rtl/affinity_group_placer.sv @@
// Top level of the affinity group placer: sequencer, group table, slot scan.
// Depends on agp_pkg, agp_thread_mem and assert_macros.svh.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_tvalid / in_tready  | in_tdata: request
//  out_    | output    | out_tvalid / out_tready| out_tdata: result
//  cfg_    | input     | cfg_we                 | cfg_index, cfg_wdata
//
// The group table scans (tag search, occupancy count, statistics) go through
// one shared read index, which sets the length of a request; placing a new
// group adds the seed reduction, the occupancy count and the slot scan.
// Reset is synchronous; no clearing pass is needed.
// in_tready is high only while the sequencer is idle; a finished result waits
// in the output register while the next request is taken.
`include "assert_macros.svh"
module affinity_group_placer #(
  parameter int MAX_THREADS = agp_pkg::MAX_THREADS_DEF,
  parameter int MAX_GROUPS  = agp_pkg::MAX_GROUPS_DEF,
  parameter int MAX_SLOTS   = agp_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // req_type[1:0], thread_id[7:2], parent_id[13:8], group_tag[45:14], zero fill
  input  logic [agp_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // status[0], thread_tag[32:1], slot[35:33], live_groups[40:36],
  // tag_min[72:41], tag_max[104:73], zero fill
  output logic [agp_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_we,
  input  logic [agp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [agp_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import agp_pkg::*;

  localparam int TIW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int GEW = $clog2(MAX_GROUPS + 1);
  localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SCW = $clog2(MAX_SLOTS + 1);
  localparam int KW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int OCW = $clog2(MAX_GROUPS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDT  = 4'd1;
  localparam logic [3:0] S_RDP  = 4'd2;
  localparam logic [3:0] S_REM  = 4'd3;
  localparam logic [3:0] S_TAG  = 4'd4;
  localparam logic [3:0] S_MOD  = 4'd5;
  localparam logic [3:0] S_OCC  = 4'd6;
  localparam logic [3:0] S_SLOT = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_RDE  = 4'd9;
  localparam logic [3:0] S_STAT = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  // Configuration registers.
  logic              hint_r, map_r;
  logic [SCNT_W-1:0] scnt_r;
  logic [SEED_W-1:0] seed_r;

  // Request registers and sequencer state.
  logic [3:0]       st_r, st_nxt;
  logic [REQ_W-1:0] req_r;
  logic [TID_W-1:0] tid_r, pid_r;
  logic [TAG_W-1:0] tag_r;
  logic             tvld_r, status_r;
  logic [GEW-1:0]   te_r;
  logic [GIW-1:0]   gi_r, g_r, freed_r, free_r;
  logic             freed_vld_r, free_fnd_r;
  logic [7:0]       rem_r;
  logic [2:0]       bc_r;
  logic [KW-1:0]    k_r, i_r, best_r;
  logic [OCW-1:0]   bo_r, cnt_r;
  logic [OCW-1:0]   occ_r [MAX_SLOTS];
  logic [TAG_W-1:0] mn_r, mx_r, ttag_r;
  logic [SLOT_W-1:0] tslot_r;
  logic             out_vld_r;
  logic [OUT_W-1:0] out_r;

  // Group table.
  logic [MAX_GROUPS-1:0] live_r;
  logic [TAG_W-1:0]      gtag_r  [MAX_GROUPS];
  logic [MEMB_W-1:0]     gmem_r  [MAX_GROUPS];
  logic [SLOT_W-1:0]     gslot_r [MAX_GROUPS];

  // Thread table port.
  logic           tm_we, tm_re;
  logic [TIW-1:0] tm_waddr, tm_raddr;
  logic [GEW-1:0] tm_wdata, tm_rdata;

  agp_thread_mem #(
    .DEPTH (MAX_THREADS),
    .AW    (TIW),
    .DW    (GEW)
  ) u_thread_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .re    (tm_re),
    .raddr (tm_raddr),
    .rdata (tm_rdata)
  );

  // Request fields and index checks.
  logic [TID_W-1:0] in_tid, in_pid;
  logic             in_tvld, pid_vld;
  logic [TIW-1:0]   tid_idx, pid_idx, in_idx;
  assign in_tid  = in_tdata[7:2];
  assign in_pid  = in_tdata[13:8];
  assign in_tvld = 32'(in_tid) < MAX_THREADS;
  assign pid_vld = 32'(pid_r) < MAX_THREADS;
  assign tid_idx = TIW'(32'(tid_r));
  assign pid_idx = TIW'(32'(pid_r));
  assign in_idx  = TIW'(32'(in_tid));

  // Clamped slot count and reduced seed.
  logic [SCW-1:0]    sc;
  logic [SEED_W-1:0] seed_m;
  always_comb begin
    if (scnt_r == '0) begin
      sc = SCW'(1);
    end else if (32'(scnt_r) > MAX_SLOTS) begin
      sc = SCW'(MAX_SLOTS);
    end else begin
      sc = SCW'(scnt_r);
    end
  end
  assign seed_m = (seed_r == SEED_MOD) ? '0 : seed_r;

  // Shared group table read at the scan index.
  logic              cur_live, hit, last_g;
  logic [TAG_W-1:0]  cur_tag;
  logic [MEMB_W-1:0] cur_mem;
  logic [SLOT_W-1:0] cur_slot;
  assign cur_live = live_r[gi_r];
  assign cur_tag  = gtag_r[gi_r];
  assign cur_mem  = gmem_r[gi_r];
  assign cur_slot = gslot_r[gi_r];
  assign hit      = cur_live && (cur_tag == tag_r);
  assign last_g   = gi_r == GIW'(MAX_GROUPS - 1);

  // Remainder step of the seed reduction.
  logic [7:0] rs, rem_nxt;
  assign rs      = {rem_r[6:0], seed_m[bc_r]};
  assign rem_nxt = (rs >= 8'(sc)) ? rs - 8'(sc) : rs;

  // Occupancy read and slot scan step. The next slot tried lies the step
  // count past the best slot found so far, wrapping at the slot count.
  logic [KW-1:0]  occ_addr, nb, k_next;
  logic [OCW-1:0] o, nbo;
  logic           slot_stop, slot_ok;
  logic [7:0]     ksum;
  assign occ_addr  = (st_r == S_OCC) ? KW'(cur_slot) : k_r;
  assign o         = occ_r[occ_addr];
  assign slot_ok   = 8'(cur_slot) < 8'(sc);
  assign slot_stop = (o == '0) || (8'(i_r) == 8'(sc) - 8'd1);
  assign ksum      = 8'(nb) + 8'(i_r) + 8'd1;
  assign k_next    = (ksum >= 8'(sc)) ? KW'(ksum - 8'(sc)) : KW'(ksum);
  always_comb begin
    nb  = best_r;
    nbo = bo_r;
    if (i_r == '0) begin
      nb  = k_r;
      nbo = o;
    end else if (o == '0 || o < bo_r) begin
      nb  = k_r;
      nbo = o;
    end
  end

  // Thread entry used for the report.
  logic [GEW-1:0] e_use;
  assign e_use = tvld_r ? tm_rdata : '0;

  // Thread table accesses.
  always_comb begin
    tm_re    = 1'b0;
    tm_raddr = tid_idx;
    tm_we    = 1'b0;
    tm_waddr = tid_idx;
    tm_wdata = '0;
    case (st_r)
      S_IDLE: begin
        tm_re    = in_tvalid && in_tvld;
        tm_raddr = in_idx;
      end
      S_RDT: begin
        tm_re    = (req_r == REQ_DUP) && pid_vld;
        tm_raddr = pid_idx;
      end
      S_REM: begin
        tm_we = 1'b1;
      end
      S_ADD: begin
        tm_we    = cur_live;
        tm_wdata = hint_r ? GEW'(32'(gi_r) + 1) : '0;
      end
      S_RDE: begin
        tm_re = tvld_r;
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_tvalid) st_nxt = in_tvld ? S_RDT : S_STAT;
      S_RDT: begin
        if (req_r == REQ_SET || req_r == REQ_TERM) begin
          st_nxt = S_REM;
        end else if (req_r == REQ_DUP && pid_vld) begin
          st_nxt = S_RDP;
        end else begin
          st_nxt = S_RDE;
        end
      end
      S_RDP: begin
        if (tm_rdata == '0 || tm_rdata == te_r) st_nxt = S_RDE;
        else st_nxt = S_REM;
      end
      S_REM: begin
        if (req_r == REQ_DUP) st_nxt = S_ADD;
        else if (req_r == REQ_SET && tag_r != '0) st_nxt = S_TAG;
        else st_nxt = S_RDE;
      end
      S_TAG: begin
        if (hit) st_nxt = S_ADD;
        else if (last_g) begin
          if (freed_vld_r || free_fnd_r || !cur_live) st_nxt = S_MOD;
          else st_nxt = S_RDE;
        end
      end
      S_MOD:  if (bc_r == '0) st_nxt = S_OCC;
      S_OCC:  if (last_g) st_nxt = S_SLOT;
      S_SLOT: if (slot_stop) st_nxt = S_ADD;
      S_ADD:  st_nxt = S_RDE;
      S_RDE:  st_nxt = S_STAT;
      S_STAT: if (last_g) st_nxt = S_OUT;
      S_OUT:  if (!out_vld_r || out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hint_r <= 1'b1;
      map_r  <= 1'b1;
      scnt_r <= SCNT_W'(4);
      seed_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HINT: hint_r <= cfg_wdata[0];
        CFG_MAP:  map_r  <= cfg_wdata[0];
        CFG_SCNT: scnt_r <= cfg_wdata[SCNT_W-1:0];
        CFG_SEED: seed_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Sequencer datapath and group table updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      live_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      // Result register: loaded at the end of a request, cleared once taken.
      if (st_r == S_OUT && (!out_vld_r || out_tready)) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            req_r       <= in_tdata[1:0];
            tid_r       <= in_tid;
            pid_r       <= in_pid;
            tag_r       <= in_tdata[45:14];
            tvld_r      <= in_tvld;
            status_r    <= 1'b0;
            freed_vld_r <= 1'b0;
            gi_r        <= '0;
            cnt_r       <= '0;
            mn_r        <= '0;
            mx_r        <= '0;
            ttag_r      <= '0;
            tslot_r     <= '0;
          end
        end
        S_RDT: begin
          te_r <= tm_rdata;
          gi_r <= GIW'(32'(tm_rdata) - 1);
        end
        S_RDP: begin
          g_r <= GIW'(32'(tm_rdata) - 1);
        end
        S_REM: begin
          // Leave the old group and free it once empty.
          if (te_r != '0) begin
            if (cur_mem <= MEMB_W'(1)) begin
              live_r[gi_r]  <= 1'b0;
              gtag_r[gi_r]  <= '0;
              gslot_r[gi_r] <= '0;
              gmem_r[gi_r]  <= '0;
              freed_vld_r   <= 1'b1;
              freed_r       <= gi_r;
            end else begin
              gmem_r[gi_r] <= cur_mem - MEMB_W'(1);
            end
          end
          gi_r       <= (req_r == REQ_DUP) ? g_r : '0;
          free_fnd_r <= 1'b0;
        end
        S_TAG: begin
          // Look for a live group with this tag and note the first free entry.
          if (!hit) begin
            gi_r <= gi_r + GIW'(1);
            if (!cur_live && !free_fnd_r) begin
              free_fnd_r <= 1'b1;
              free_r     <= gi_r;
            end
          end
          if (!hit && last_g) begin
            if (freed_vld_r) g_r <= freed_r;
            else if (free_fnd_r) g_r <= free_r;
            else g_r <= gi_r;
            if (!freed_vld_r && !free_fnd_r && cur_live) status_r <= 1'b1;
            rem_r <= '0;
            bc_r  <= 3'd6;
            for (int s = 0; s < MAX_SLOTS; s++) occ_r[s] <= '0;
          end
        end
        S_MOD: begin
          // One bit of the start slot remainder per cycle.
          rem_r <= rem_nxt;
          bc_r  <= bc_r - 3'd1;
          gi_r  <= '0;
          if (bc_r == '0) begin
            k_r <= map_r ? KW'(rem_nxt) : '0;
            i_r <= '0;
          end
        end
        S_OCC: begin
          // Count live groups per slot in use.
          if (cur_live && slot_ok) occ_r[occ_addr] <= o + OCW'(1);
          gi_r <= gi_r + GIW'(1);
        end
        S_SLOT: begin
          best_r <= nb;
          bo_r   <= nbo;
          k_r    <= k_next;
          i_r    <= i_r + KW'(1);
          if (slot_stop) begin
            live_r[g_r]  <= 1'b1;
            gtag_r[g_r]  <= tag_r;
            gmem_r[g_r]  <= '0;
            gslot_r[g_r] <= SLOT_W'(nb);
            gi_r         <= g_r;
          end
        end
        S_ADD: begin
          if (cur_live && cur_mem < MEMBER_MAX) begin
            gmem_r[gi_r] <= cur_mem + MEMB_W'(1);
          end
        end
        S_RDE: begin
          gi_r <= '0;
        end
        S_STAT: begin
          // Live count, tag range and the thread's own group.
          if (cur_live) begin
            if (cnt_r == '0 || cur_tag < mn_r) mn_r <= cur_tag;
            if (cnt_r == '0 || cur_tag > mx_r) mx_r <= cur_tag;
            cnt_r <= cnt_r + OCW'(1);
            if (32'(e_use) == 32'(gi_r) + 1) begin
              ttag_r  <= cur_tag;
              tslot_r <= cur_slot;
            end
          end
          gi_r <= gi_r + GIW'(1);
        end
        S_OUT: begin
          if (!out_vld_r || out_tready) begin
            out_r <= {7'd0, mx_r, mn_r, LIVE_W'(cnt_r), tslot_r, ttag_r, status_r};
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_tready  = st_r == S_IDLE;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  `AGP_ASSERT_IMP(a_short_no_tag, clk, rst_n, out_vld_r && out_r[0], out_r[32:1] == '0)
  `AGP_ASSERT_IMP(a_tag_order, clk, rst_n, out_vld_r, out_r[72:41] <= out_r[104:73])
  `AGP_ASSERT_IMP(a_empty_range, clk, rst_n, out_vld_r && out_r[40:36] == '0,
                  out_r[72:41] == '0 && out_r[104:73] == '0)
  `AGP_ASSERT_IMP(a_scan_bound, clk, rst_n, st_r == S_SLOT, 8'(k_r) < 8'(sc))

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the affinity group placer: directed and random requests.
// Depends on agp_pkg and the affinity_group_placer RTL; predicts each result itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import agp_pkg::*;

  // Request kind that the block leaves undefined.
  localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  // Result fields, highest bits first.
  typedef struct packed {
    logic [TAG_W-1:0] tag_max;
    logic [TAG_W-1:0] tag_min;
    logic [LIVE_W-1:0] live_groups;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0] thread_tag;
    logic [0:0] status;
  } placement_t;

  // Shadow copy of the block's registers and tables.
  logic hint_on, map_on;
  logic [SCNT_W-1:0] slot_cnt;
  logic [SEED_W-1:0] seed;
  logic grp_live [16];
  logic [TAG_W-1:0] grp_tag [16];
  logic [MEMB_W-1:0] grp_memb [16];
  logic [SLOT_W-1:0] grp_slot [16];
  logic [4:0] thr_grp [64];

  placement_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit quiet = 0;
  bit rx_stall_on = 1;

  affinity_group_placer uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter with a generous limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic report(input string what, input logic [TAG_W-1:0] got, exp_v);
    errors++;
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp_v, cycles);
  endtask

  function automatic void clear_model();
    hint_on = 1; map_on = 1; slot_cnt = 4; seed = 0;
    for (int i = 0; i < 16; i++) begin
      grp_live[i] = 0; grp_tag[i] = 0; grp_memb[i] = 0; grp_slot[i] = 0;
    end
    for (int i = 0; i < 64; i++) thr_grp[i] = 0;
  endfunction

  // Take a thread out of its group; returns the freed entry or -1.
  function automatic int leave_group(input int t);
    int e;
    e = thr_grp[t];
    thr_grp[t] = 0;
    if (e == 0) return -1;
    if (grp_memb[e-1] > 0) grp_memb[e-1]--;
    if (grp_memb[e-1] == 0) begin
      grp_live[e-1] = 0; grp_tag[e-1] = 0; grp_slot[e-1] = 0;
      return e - 1;
    end
    return -1;
  endfunction

  function automatic void join_group(input int g, input int t);
    if (grp_memb[g] < MEMBER_MAX) grp_memb[g]++;
    thr_grp[t] = hint_on ? 5'(g + 1) : 5'd0;
  endfunction

  // Least-occupied slot search, stopping at the first empty slot.
  function automatic void place_group(input int g, input logic [TAG_W-1:0] tag);
    int occ [8];
    int sc, k, best;
    sc = slot_cnt == 0 ? 1 : (slot_cnt > 8 ? 8 : slot_cnt);
    for (int i = 0; i < 8; i++) occ[i] = 0;
    for (int i = 0; i < 16; i++)
      if (grp_live[i] && grp_slot[i] < sc) occ[grp_slot[i]]++;
    best = map_on ? ((seed % 127) % sc) : 0;
    for (int i = 0; i < sc; i++) begin
      k = (best + i) % sc;
      if (occ[k] == 0) begin
        best = k;
        break;
      end
      if (occ[k] < occ[best]) best = k;
    end
    grp_live[g] = 1; grp_tag[g] = tag; grp_memb[g] = 0; grp_slot[g] = 3'(best);
  endfunction

  function automatic placement_t predict_placement(input logic [1:0] kind, input int t,
                                                   input int p, input logic [TAG_W-1:0] tag);
    placement_t r;
    int freed, g, pe, cnt;
    r = '0;
    cnt = 0;
    if (kind == REQ_SET) begin
      freed = leave_group(t);
      if (tag != 0) begin
        g = -1;
        for (int i = 0; i < 16; i++)
          if (g < 0 && grp_live[i] && grp_tag[i] == tag) g = i;
        if (g < 0) begin
          g = freed;
          for (int i = 0; i < 16; i++)
            if (g < 0 && !grp_live[i]) g = i;
          if (g >= 0) place_group(g, tag);
        end
        if (g < 0) r.status = 1;
        else join_group(g, t);
      end
    end else if (kind == REQ_DUP) begin
      pe = thr_grp[p];
      if (pe != 0 && thr_grp[t] != pe) begin
        void'(leave_group(t));
        if (grp_live[pe-1]) join_group(pe - 1, t);
      end
    end else if (kind == REQ_TERM) begin
      void'(leave_group(t));
    end
    if (thr_grp[t] != 0 && grp_live[thr_grp[t]-1]) begin
      r.thread_tag = grp_tag[thr_grp[t]-1];
      r.slot = grp_slot[thr_grp[t]-1];
    end
    for (int i = 0; i < 16; i++) begin
      if (!grp_live[i]) continue;
      if (cnt == 0 || grp_tag[i] < r.tag_min) r.tag_min = grp_tag[i];
      if (cnt == 0 || grp_tag[i] > r.tag_max) r.tag_max = grp_tag[i];
      cnt++;
    end
    r.live_groups = 5'(cnt);
    return r;
  endfunction

  // Send one request after an optional idle burst; valid drops once it is taken.
  task automatic send_request(input logic [1:0] kind, input int t, input int p,
                              input logic [TAG_W-1:0] tag);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b0, tag, 6'(p), 6'(t), kind};
    do @(posedge clk); while (!in_tready);
    pending_q.push_back(predict_placement(kind, t, p, tag));
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stall bursts, then check against the oldest prediction.
  always @(posedge clk) begin
    placement_t got, want;
    if (out_tvalid && out_tready) begin
      got = placement_t'(out_tdata[104:0]);
      if (pending_q.size() == 0) begin
        report("unexpected result", got.thread_tag, 0);
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.thread_tag !== want.thread_tag) report("thread_tag", got.thread_tag, want.thread_tag);
        if (got.slot !== want.slot) report("slot", got.slot, want.slot);
        if (got.live_groups !== want.live_groups)
          report("live_groups", got.live_groups, want.live_groups);
        if (got.tag_min !== want.tag_min) report("tag_min", got.tag_min, want.tag_min);
        if (got.tag_max !== want.tag_max) report("tag_max", got.tag_max, want.tag_max);
      end
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && !quiet && rx_stall_on && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // One register write; the caller drops the write enable after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DAT_W'(val);
    @(posedge clk);
    case (idx)
      CFG_HINT: hint_on = val[0];
      CFG_MAP: map_on = val[0];
      CFG_SCNT: slot_cnt = val[3:0];
      CFG_SEED: seed = val[6:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input int h, m, s, sd);
    drain();
    write_reg(CFG_HINT, h);
    write_reg(CFG_MAP, m);
    write_reg(CFG_SCNT, s);
    write_reg(CFG_SEED, sd);
    cfg_we <= 1'b0;
  endtask

  // Directed: extreme tags, every request kind, shortage, dup cases, bad kind.
  task automatic test_directed();
    send_request(REQ_SET, 0, 0, 32'hFFFF_FFFF);
    send_request(REQ_SET, 63, 0, 32'h1);
    send_request(REQ_DUP, 5, 63, 0);
    send_request(REQ_DUP, 5, 63, 0);
    send_request(REQ_DUP, 6, 40, 0);
    send_request(REQ_DUP, 5, 0, 0);
    send_request(REQ_SET, 63, 0, 0);
    send_request(REQ_TERM, 0, 0, 0);
    send_request(REQ_UNDEF, 5, 21, 32'hA5A5_5A5A);
    for (int i = 0; i < 17; i++) send_request(REQ_SET, 10 + i, 0, 32'h100 + i);
    send_request(REQ_TERM, 5, 0, 0);
  endtask

  // Random traffic; small tag pool so groups are shared and reused, or wide tags.
  task automatic test_random(input int n, input bit wide_tags);
    int k;
    logic [TAG_W-1:0] tag;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      tag = wide_tags ? $urandom() : 32'($urandom_range(0, 20));
      if (k < 9) send_request(REQ_SET, $urandom_range(0, 63), $urandom_range(0, 63), tag);
      else if (k < 15) send_request(REQ_DUP, $urandom_range(0, 63), $urandom_range(0, 63), tag);
      else if (k < 19) send_request(REQ_TERM, $urandom_range(0, 63), $urandom_range(0, 63), tag);
      else send_request(REQ_UNDEF, $urandom_range(0, 63), $urandom_range(0, 63), tag);
    end
  endtask

  // Member saturation: many threads on one tag with hinting off.
  task automatic test_saturation();
    for (int i = 0; i < 140; i++) send_request(REQ_SET, i % 64, 0, 32'h77);
  endtask

  initial begin
    clear_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500, 0);
    set_config(0, 0, 1, 126);
    test_random(150, 0);
    test_saturation();
    set_config(1, 1, 8, 127);
    test_random(400, 0);
    set_config(1, 1, 15, 93);
    test_random(200, 1);
    set_config(1, 0, 0, 0);
    test_random(150, 0);
    set_config(1, 1, 3, 64);
    test_random(300, 0);
    drain();
    quiet = 1;
    test_random(200, 0);
    drain();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

@@ affinity_group_placer.f @@
+incdir+rtl
rtl/agp_pkg.sv
rtl/agp_thread_mem.sv
rtl/affinity_group_placer.sv
bench/tb_top.sv
